[hdl/md4_pkg.sv]
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and step helpers for the MD4 digest unit.
// ----------------------------------------------------------------------------
package md4_pkg;

  // Initial chaining words
  localparam logic [31:0] MD4_INIT0 = 32'h67452301;
  localparam logic [31:0] MD4_INIT1 = 32'hefcdab89;
  localparam logic [31:0] MD4_INIT2 = 32'h98badcfe;
  localparam logic [31:0] MD4_INIT3 = 32'h10325476;

  // Round additive constants
  localparam logic [31:0] MD4_K2 = 32'h5A827999;
  localparam logic [31:0] MD4_K3 = 32'h6ED9EBA1;

  // Padding marker byte and step bookkeeping
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LAST_STEP  = 6'd47;
  localparam logic [3:0] LAST_WORD  = 4'd15;
  localparam logic [3:0] LEN_LO_IDX = 4'd14;
  localparam logic [3:0] LEN_HI_IDX = 4'd15;
  localparam logic [5:0] LAST_OFF   = 6'h3F;
  localparam logic [1:0] LAST_DIGEST_IDX = 2'd3;

  // Round codes (step counter bits 5:4)
  localparam logic [1:0] ROUND_F = 2'd0;
  localparam logic [1:0] ROUND_G = 2'd1;
  localparam logic [1:0] ROUND_H = 2'd2;

  // Input action codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FOLD,
    S_EMIT
  } state_t;

  // Rotate left by 1..31
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

  // Rotation amount per round and step position
  function automatic logic [4:0] shift_amt(input logic [1:0] rnd, input logic [1:0] pos);
    logic [4:0] s;
    s = 5'd3;
    case (rnd)
      ROUND_F: begin
        case (pos)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      ROUND_G: begin
        case (pos)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (pos)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // Message word index per round: direct, transposed, bit reversed
  function automatic logic [3:0] word_sel(input logic [1:0] rnd, input logic [3:0] j);
    logic [3:0] k;
    case (rnd)
      ROUND_F: k = j;
      ROUND_G: k = {j[1:0], j[3:2]};
      default: k = {j[0], j[1], j[2], j[3]};
    endcase
    return k;
  endfunction

  // Replace one byte lane of a word
  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

  // Keep lanes below, marker in this lane, zeros above
  function automatic logic [31:0] pad_lane(input logic [31:0] w, input logic [1:0] lane);
    logic [31:0] r;
    case (lane)
      2'd0:    r = {24'h0, PAD_BYTE};
      2'd1:    r = {16'h0, PAD_BYTE, w[7:0]};
      2'd2:    r = {8'h0, PAD_BYTE, w[15:0]};
      default: r = {PAD_BYTE, w[23:0]};
    endcase
    return r;
  endfunction

endpackage

[hdl/md4_message_digest_unit.sv]
// ----------------------------------------------------------------------------
// md4_message_digest_unit
// MD4 digest over a byte stream; one shared step unit runs all 48 steps.
// Append word: taken in S_IDLE; the 64th byte of a block then runs the 48 steps
//   in the shared round unit plus one chaining fold.
// Finish word: zero fill to the end of the block, the 48 steps and the fold,
//   plus a second padded block when the length spills over, then 4 digest words out.
// One word in flight at a time; in_tready is low while compressing and, after a finish, until the digest leaves.
// Synchronous active-low reset loads the initial chain and a zero count.
// ----------------------------------------------------------------------------
module md4_message_digest_unit
  import md4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] action
  // digest stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last
);

  state_t      state_r, state_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] work_r [4];
  logic [31:0] work_nxt [4];
  logic [31:0] blk_r [16];
  logic [63:0] count_r, count_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [3:0]  pad_idx_r, pad_idx_nxt;
  logic [1:0]  emit_idx_r, emit_idx_nxt;
  logic        fin_r, fin_nxt;
  logic        extra_r, extra_nxt;

  logic        blk_we;
  logic [3:0]  blk_wa;
  logic [31:0] blk_wd;

  logic [5:0]  off;
  logic [3:0]  cur_w;
  logic [63:0] bit_len;

  // shared step unit signals
  logic [1:0]  rnd;
  logic [31:0] f_val, x_val, step_sum, step_new;

  assign off     = count_r[5:0];
  assign cur_w   = off[5:2];
  assign bit_len = {count_r[60:0], 3'b000};

  // Step unit: one MD4 step per cycle
  assign rnd = step_r[5:4];
  always_comb begin
    case (rnd)
      ROUND_F: f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      ROUND_G: f_val = ((work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) |
                        (work_r[2] & work_r[3])) + MD4_K2;
      default: f_val = (work_r[1] ^ work_r[2] ^ work_r[3]) + MD4_K3;
    endcase
  end
  assign x_val    = blk_r[word_sel(rnd, step_r[3:0])];
  assign step_sum = work_r[0] + f_val + x_val;
  assign step_new = rotl32(step_sum, shift_amt(rnd, step_r[1:0]));

  // Digest output
  assign out_tdata = chain_r[emit_idx_r];
  assign out_tuser = emit_idx_r;
  assign out_tlast = (emit_idx_r == LAST_DIGEST_IDX);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    chain_nxt    = chain_r;
    work_nxt     = work_r;
    count_nxt    = count_r;
    step_nxt     = step_r;
    pad_idx_nxt  = pad_idx_r;
    emit_idx_nxt = emit_idx_r;
    fin_nxt      = fin_r;
    extra_nxt    = extra_r;
    blk_we       = 1'b0;
    blk_wa       = cur_w;
    blk_wd       = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          blk_we = 1'b1;
          if (in_tuser == ACT_APPEND) begin
            blk_wd    = put_lane(blk_r[cur_w], off[1:0], in_tdata);
            count_nxt = count_r + 64'd1;
            if (off == LAST_OFF) begin
              work_nxt  = chain_r;
              step_nxt  = '0;
              state_nxt = S_COMP;
            end
          end else begin
            blk_wd    = pad_lane(blk_r[cur_w], off[1:0]);
            fin_nxt   = 1'b1;
            extra_nxt = (off[5:3] == 3'b111);
            if (cur_w == LAST_WORD) begin
              work_nxt  = chain_r;
              step_nxt  = '0;
              state_nxt = S_COMP;
            end else begin
              pad_idx_nxt = cur_w + 4'd1;
              state_nxt   = S_PAD;
            end
          end
        end
      end

      // zero fill, with the bit length in the final block
      S_PAD: begin
        blk_we = 1'b1;
        blk_wa = pad_idx_r;
        if (!extra_r && pad_idx_r == LEN_LO_IDX) begin
          blk_wd = bit_len[31:0];
        end else if (!extra_r && pad_idx_r == LEN_HI_IDX) begin
          blk_wd = bit_len[63:32];
        end
        if (pad_idx_r == LAST_WORD) begin
          work_nxt  = chain_r;
          step_nxt  = '0;
          state_nxt = S_COMP;
        end else begin
          pad_idx_nxt = pad_idx_r + 4'd1;
        end
      end

      S_COMP: begin
        work_nxt[0] = work_r[3];
        work_nxt[1] = step_new;
        work_nxt[2] = work_r[1];
        work_nxt[3] = work_r[2];
        if (step_r == LAST_STEP) begin
          state_nxt = S_FOLD;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end

      S_FOLD: begin
        for (int i = 0; i < 4; i++) chain_nxt[i] = chain_r[i] + work_r[i];
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (extra_r) begin
          extra_nxt   = 1'b0;
          pad_idx_nxt = '0;
          state_nxt   = S_PAD;
        end else begin
          emit_idx_nxt = '0;
          state_nxt    = S_EMIT;
        end
      end

      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (emit_idx_r == LAST_DIGEST_IDX) begin
            chain_nxt[0] = MD4_INIT0;
            chain_nxt[1] = MD4_INIT1;
            chain_nxt[2] = MD4_INIT2;
            chain_nxt[3] = MD4_INIT3;
            count_nxt    = '0;
            fin_nxt      = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 2'd1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= MD4_INIT0;
      chain_r[1] <= MD4_INIT1;
      chain_r[2] <= MD4_INIT2;
      chain_r[3] <= MD4_INIT3;
      count_r    <= '0;
      fin_r      <= 1'b0;
      extra_r    <= 1'b0;
      step_r     <= '0;
      pad_idx_r  <= '0;
      emit_idx_r <= '0;
    end else begin
      chain_r    <= chain_nxt;
      count_r    <= count_nxt;
      fin_r      <= fin_nxt;
      extra_r    <= extra_nxt;
      step_r     <= step_nxt;
      pad_idx_r  <= pad_idx_nxt;
      emit_idx_r <= emit_idx_nxt;
    end
  end

  // Working words and block buffer (no reset)
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (blk_we) begin
      blk_r[blk_wa] <= blk_wd;
    end
  end

  // Checks
  a_emit_only_finishing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fin_r && !extra_r))
    else $error("digest shown outside a finish");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while digest pending");

  a_extra_needs_fin: assert property (@(posedge clk) disable iff (!rst_n)
    extra_r |-> fin_r)
    else $error("extra pad block without finish");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (count_r == '0 && chain_r[0] == MD4_INIT0 && !fin_r))
    else $error("chain not reinitialized after digest");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && step_r == LAST_STEP) |=> (state_r == S_FOLD))
    else $error("compression did not fold after last step");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for md4_message_digest_unit: byte messages go in on the
// input stream, a local MD4 model predicts the four digest words of every
// finish, and a checker compares each digest word leaving the unit.
// ----------------------------------------------------------------------------
module tb
  import md4_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int LEN_FIELD_OFF  = 56;    // byte where the bit length starts

  // Rotation per round (F, G, H) and step position, 5 bits each, lowest first
  localparam logic [59:0] ROT_TABLE = {5'd15, 5'd11, 5'd9, 5'd3,
                                       5'd13, 5'd9,  5'd5, 5'd3,
                                       5'd19, 5'd11, 5'd7, 5'd3};

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  pos;
    logic        fin;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] digest_word
  logic [1:0]  out_tuser;          // [1:0] word_index
  logic        out_tlast;

  // MD4 model state
  logic [31:0] chain_words [4];
  logic [7:0]  block_bytes [64];
  logic [63:0] msg_len;
  digest_word_t digest_expect [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  md4_message_digest_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] block_word(input int w);
    return {block_bytes[4*w+3], block_bytes[4*w+2], block_bytes[4*w+1], block_bytes[4*w]};
  endfunction

  function automatic void restart_chain();
    chain_words[0] = MD4_INIT0;
    chain_words[1] = MD4_INIT1;
    chain_words[2] = MD4_INIT2;
    chain_words[3] = MD4_INIT3;
    msg_len = '0;
  endfunction

  // Three rounds of 16 steps over the buffered block
  function automatic void fold_block();
    logic [31:0] a, b, c, d, f, x, t;
    int k, r, p, w;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (k = 0; k < 48; k++) begin
      r = k / 16;
      p = k % 16;
      if (r == 0) begin
        f = (b & c) | (~b & d);
        w = p;
      end else if (r == 1) begin
        f = ((b & c) | (b & d) | (c & d)) + MD4_K2;
        w = (p % 4) * 4 + p / 4;
      end else begin
        f = (b ^ c ^ d) + MD4_K3;
        w = ((p & 1) << 3) | ((p & 2) << 1) | ((p & 4) >> 1) | ((p & 8) >> 3);
      end
      x = block_word(w);
      t = rot_left(a + f + x, int'(ROT_TABLE[(r * 4 + k % 4) * 5 +: 5]));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
  endfunction

  // Advance the model by one accepted input word
  function automatic void model_word(input logic act, input logic [7:0] data);
    int off, i;
    logic [63:0] bits;
    digest_word_t e;
    off = int'(msg_len[5:0]);
    if (act == ACT_APPEND) begin
      block_bytes[off] = data;
      msg_len += 64'd1;
      if (off == 63) fold_block();
    end else begin
      block_bytes[off] = PAD_BYTE;
      for (i = off + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // no room for the length: close this block, length goes in a fresh one
      if (off >= LEN_FIELD_OFF) begin
        fold_block();
        for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      bits = msg_len << 3;
      for (i = 0; i < 8; i++) block_bytes[LEN_FIELD_OFF + i] = bits[8*i +: 8];
      fold_block();
      for (i = 0; i < 4; i++) begin
        e.word = chain_words[i];
        e.pos  = 2'(i);
        e.fin  = (2'(i) == LAST_DIGEST_IDX);
        digest_expect.push_back(e);
      end
      restart_chain();
    end
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) model_word(in_tuser, in_tdata);
  end

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare each digest word with the oldest prediction
  always @(posedge clk) begin : check_digest
    digest_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_expect.size() == 0) begin
        flag_error("digest word with none expected", out_tdata, 32'h0);
      end else begin
        e = digest_expect.pop_front();
        if (out_tdata !== e.word) flag_error("digest_word", out_tdata, e.word);
        if (out_tuser !== e.pos) flag_error("word_index", 32'(out_tuser), 32'(e.pos));
        if (out_tlast !== e.fin) flag_error("last", 32'(out_tlast), 32'(e.fin));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Offer one word; valid is left high after acceptance for the next one
  task automatic push_word(input logic act, input logic [7:0] data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid; it stays low until the next word is offered
  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) push_word(ACT_APPEND, 8'($urandom_range(0, 255)));
    push_word(ACT_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Short messages of random length
  task automatic send_random_message();
    send_message($urandom_range(0, 3));
  endtask

  // Empty message, both byte extremes, and a short text
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_word(ACT_FINISH, 8'h00);
    push_word(ACT_APPEND, 8'h00);
    push_word(ACT_FINISH, 8'hFF);
    push_word(ACT_APPEND, 8'hFF);
    push_word(ACT_FINISH, 8'h00);
    push_word(ACT_APPEND, 8'h61);
    push_word(ACT_APPEND, 8'h62);
    push_word(ACT_APPEND, 8'h63);
    push_word(ACT_FINISH, 8'hA5);
    release_input();
  endtask

  // One full block, then a finish at byte 56 that spills the length over
  task automatic test_pad_boundary();
    send_message(120);
    release_input();
  endtask

  task automatic test_idle_phase(input int send_pct, input int recv_pct, input int count);
    int m;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (m = 0; m < count; m++) send_random_message();
    release_input();
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    send_message(3);
    send_message(0);
    release_input();
  endtask

  initial begin
    restart_chain();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pad_boundary();
    test_idle_phase(0, 0, 2);
    test_idle_phase(81, 0, 2);
    test_idle_phase(0, 81, 2);
    test_idle_phase(35, 35, 2);
    test_backpressure();

    while (digest_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/md4_pkg.sv
hdl/md4_message_digest_unit.sv
test/tb.sv
